### hw/rtl/glmt_pkg.sv
// Shared types and constants for the greedy longest match tokenizer.
`default_nettype none
package glmt_pkg;

    localparam int ENTRY_BYTES = 16;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] NORM_BYTE0 = 8'hE2;
    localparam logic [7:0] NORM_BYTE1 = 8'h96;
    localparam logic [7:0] NORM_BYTE2 = 8'h81;

    typedef enum logic [1:0] {
        KIND_VOCAB = 2'd0,
        KIND_START = 2'd1,
        KIND_TEXT  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_BEGIN_ID    = 2'd0,
        CFG_UNKNOWN_ID  = 2'd1,
        CFG_ENTRIES     = 2'd2,
        CFG_MAX_TOKENS  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_SHIFT,
        ST_DRAIN,
        ST_CLOSE
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/greedy_longest_match_tokenizer_top.sv
// Top level of the greedy longest match tokenizer: vocabulary store, window and sequencer.
//
//  channel | direction | signals                                            | beat
//  --------+-----------+----------------------------------------------------+-------------------
//  in      | input     | in_valid/in_ready, kind, entry_index, byte_offset, | one command
//          |           | entry_length, data_byte                            |
//  out     | output    | out_valid/out_ready, token_id, token_valid, last,  | one token or close
//          |           | token_count                                        |
//  cfg     | input     | cfg_valid/cfg_ready, cfg_index, cfg_data           | one register write
//
// Each token the matcher produces costs one scan of the vocabulary store, one entry row
// per cycle through its single read port, and a window shift per consumed byte. A text
// beat scans only when the window is full, so it runs up to three scans; an end beat
// runs one scan per token left in the window.
// Reset clears the sequencer, the window fill and the counters, and sets the
// configuration registers to their defaults; the vocabulary store is not cleared.
// A stalled output holds the sequencer in the emit or close state; in_ready is high
// only while the sequencer is idle.
`default_nettype none
module greedy_longest_match_tokenizer_top #(
    parameter int VOCAB_ENTRIES = 4096,
    parameter int WINDOW_LEN    = 16,
    parameter int NORM_CAP      = 4093
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [11:0] entry_index,
    input  wire logic [3:0]  byte_offset,
    input  wire logic [4:0]  entry_length,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      token_id,
    output logic             token_valid,
    output logic             last,
    output logic [15:0]      token_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AW  = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1;
    localparam int CW  = AW + 1;
    localparam int FW  = $clog2(WINDOW_LEN + 1);
    localparam int WIW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int NW  = $clog2(NORM_CAP + 3);
    localparam int EB  = glmt_pkg::ENTRY_BYTES;

    // Configuration registers.
    logic [11:0] begin_id_reg;
    logic [11:0] unknown_id_reg;
    logic [12:0] entries_reg;
    logic [15:0] max_tokens_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            begin_id_reg   <= 12'd1;
            unknown_id_reg <= 12'd0;
            entries_reg    <= 13'd0;
            max_tokens_reg <= 16'hFFFF;
        end else if (cfg_valid) begin
            unique case (glmt_pkg::cfg_index_t'(cfg_index))
                glmt_pkg::CFG_BEGIN_ID:   begin_id_reg   <= cfg_data[11:0];
                glmt_pkg::CFG_UNKNOWN_ID: unknown_id_reg <= cfg_data[11:0];
                glmt_pkg::CFG_ENTRIES:    entries_reg    <= cfg_data[12:0];
                glmt_pkg::CFG_MAX_TOKENS: max_tokens_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state.
    glmt_pkg::state_t state_reg, state_next;
    logic [7:0]     window_reg [WINDOW_LEN];
    logic [7:0]     window_next [WINDOW_LEN];
    logic [FW-1:0]  fill_reg, fill_next;
    logic [NW-1:0]  norm_reg, norm_next;
    logic [15:0]    cnt_reg, cnt_next;
    logic           space_reg, space_next;
    logic [7:0]     byte_reg, byte_next;
    logic [1:0]     pidx_reg, pidx_next;
    logic           draining_reg, draining_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic           rd_valid_reg, rd_valid_next;
    logic [AW-1:0]  rd_idx_reg;
    logic [4:0]     match_len_reg, match_len_next;
    logic [AW-1:0]  best_id_reg, best_id_next;
    logic [11:0]    emit_id_reg, emit_id_next;
    logic           from_match_reg, from_match_next;
    logic [4:0]     consume_reg, consume_next;
    logic           out_valid_reg, out_valid_next;
    logic [11:0]    out_id_reg, out_id_next;
    logic           out_tv_reg, out_tv_next;
    logic           out_last_reg, out_last_next;
    logic [15:0]    out_cnt_reg, out_cnt_next;

    // Vocabulary store: one row of entry bytes per entry, plus its length.
    logic [7:0]     vocab_mem [VOCAB_ENTRIES][EB];
    logic [4:0]     len_mem [VOCAB_ENTRIES];
    logic [7:0]     row_reg [EB];
    logic [4:0]     len_reg;

    logic           in_fire;
    logic           wr_en;
    logic           issue;
    logic [16:0]    limit;
    logic [16:0]    eiu_ext;
    logic           out_free;
    logic [7:0]     push_byte;
    logic [7:0]     win_pad [EB];
    logic           hit;

    assign in_ready  = (state_reg == glmt_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign wr_en     = in_fire && (glmt_pkg::kind_t'(kind) == glmt_pkg::KIND_VOCAB)
                       && (17'(entry_index) < 17'(VOCAB_ENTRIES));
    assign eiu_ext   = 17'(entries_reg);
    assign limit     = (eiu_ext > 17'(VOCAB_ENTRIES)) ? 17'(VOCAB_ENTRIES) : eiu_ext;
    assign issue     = (state_reg == glmt_pkg::ST_SCAN) && (17'(scan_reg) < limit);
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            vocab_mem[entry_index[AW-1:0]][byte_offset] <= data_byte;
            len_mem[entry_index[AW-1:0]]                <= entry_length;
        end
        if (issue) begin
            row_reg    <= vocab_mem[scan_reg[AW-1:0]];
            len_reg    <= len_mem[scan_reg[AW-1:0]];
            rd_idx_reg <= scan_reg[AW-1:0];
        end
    end

    // Window bytes padded to the entry width; bytes past the window never count.
    for (genvar k = 0; k < EB; k++) begin : g_pad
        if (k < WINDOW_LEN) begin : g_in
            assign win_pad[k] = window_reg[k];
        end else begin : g_out
            assign win_pad[k] = 8'd0;
        end
    end

    // Compare the fetched entry against the window head.
    always_comb begin
        logic ok;
        ok = (len_reg != 5'd0) && (len_reg <= 5'(EB))
             && ({1'b0, len_reg} <= 6'(fill_reg)) && (len_reg > match_len_reg);
        for (int k = 0; k < EB; k++) begin
            ok = ok && ((5'(k) >= len_reg) || (row_reg[k] == win_pad[k]));
        end
        hit = rd_valid_reg && ok;
    end

    always_comb begin
        priority if (!space_reg) push_byte = byte_reg;
        else if (pidx_reg == 2'd0) push_byte = glmt_pkg::NORM_BYTE0;
        else if (pidx_reg == 2'd1) push_byte = glmt_pkg::NORM_BYTE1;
        else push_byte = glmt_pkg::NORM_BYTE2;
    end

    always_comb begin
        state_next      = state_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        norm_next       = norm_reg;
        cnt_next        = cnt_reg;
        space_next      = space_reg;
        byte_next       = byte_reg;
        pidx_next       = pidx_reg;
        draining_next   = draining_reg;
        scan_next       = scan_reg;
        rd_valid_next   = 1'b0;
        match_len_next  = match_len_reg;
        best_id_next    = best_id_reg;
        emit_id_next    = emit_id_reg;
        from_match_next = from_match_reg;
        consume_next    = consume_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_id_next     = out_id_reg;
        out_tv_next     = out_tv_reg;
        out_last_next   = out_last_reg;
        out_cnt_next    = out_cnt_reg;

        unique case (state_reg)
            glmt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (glmt_pkg::kind_t'(kind))
                        glmt_pkg::KIND_VOCAB: ;
                        glmt_pkg::KIND_START: begin
                            fill_next       = '0;
                            norm_next       = '0;
                            cnt_next        = '0;
                            emit_id_next    = begin_id_reg;
                            from_match_next = 1'b0;
                            state_next      = glmt_pkg::ST_EMIT;
                        end
                        glmt_pkg::KIND_TEXT: begin
                            if (norm_reg < NW'(NORM_CAP)) begin
                                space_next    = (data_byte == glmt_pkg::SPACE_BYTE);
                                byte_next     = data_byte;
                                pidx_next     = 2'd0;
                                draining_next = 1'b0;
                                state_next    = glmt_pkg::ST_PUSH;
                            end
                        end
                        glmt_pkg::KIND_END: begin
                            draining_next = 1'b1;
                            state_next    = glmt_pkg::ST_DRAIN;
                        end
                        default: ;
                    endcase
                end
            end
            glmt_pkg::ST_PUSH: begin
                if (fill_reg == FW'(WINDOW_LEN)) begin
                    scan_next      = '0;
                    match_len_next = 5'd0;
                    state_next     = glmt_pkg::ST_SCAN;
                end else begin
                    window_next[fill_reg[WIW-1:0]] = push_byte;
                    fill_next = fill_reg + 1'b1;
                    norm_next = norm_reg + 1'b1;
                    if (!space_reg || pidx_reg == 2'd2) begin
                        state_next = glmt_pkg::ST_IDLE;
                    end else begin
                        pidx_next = pidx_reg + 2'd1;
                    end
                end
            end
            glmt_pkg::ST_SCAN: begin
                if (hit) begin
                    match_len_next = len_reg;
                    best_id_next   = rd_idx_reg;
                end
                if (issue) begin
                    rd_valid_next = 1'b1;
                    scan_next     = scan_reg + 1'b1;
                end else begin
                    state_next = glmt_pkg::ST_DECIDE;
                end
            end
            glmt_pkg::ST_DECIDE: begin
                from_match_next = 1'b1;
                if (match_len_reg == 5'd0) begin
                    emit_id_next = unknown_id_reg;
                    consume_next = 5'd1;
                end else begin
                    emit_id_next = 12'(best_id_reg);
                    consume_next = match_len_reg;
                end
                state_next = glmt_pkg::ST_EMIT;
            end
            glmt_pkg::ST_EMIT: begin
                if (cnt_reg >= max_tokens_reg) begin
                    state_next = from_match_reg ? glmt_pkg::ST_SHIFT : glmt_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_id_next    = emit_id_reg;
                    out_tv_next    = 1'b1;
                    out_last_next  = 1'b0;
                    out_cnt_next   = cnt_reg + 16'd1;
                    cnt_next       = cnt_reg + 16'd1;
                    state_next = from_match_reg ? glmt_pkg::ST_SHIFT : glmt_pkg::ST_IDLE;
                end
            end
            glmt_pkg::ST_SHIFT: begin
                for (int k = 0; k < WINDOW_LEN - 1; k++) begin
                    window_next[k] = window_reg[k + 1];
                end
                window_next[WINDOW_LEN - 1] = 8'd0;
                fill_next    = fill_reg - 1'b1;
                consume_next = consume_reg - 5'd1;
                if (consume_reg == 5'd1) begin
                    state_next = draining_reg ? glmt_pkg::ST_DRAIN : glmt_pkg::ST_PUSH;
                end
            end
            glmt_pkg::ST_DRAIN: begin
                if (fill_reg != '0) begin
                    scan_next      = '0;
                    match_len_next = 5'd0;
                    state_next     = glmt_pkg::ST_SCAN;
                end else begin
                    state_next = glmt_pkg::ST_CLOSE;
                end
            end
            glmt_pkg::ST_CLOSE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_id_next    = 12'd0;
                    out_tv_next    = 1'b0;
                    out_last_next  = 1'b1;
                    out_cnt_next   = cnt_reg;
                    fill_next      = '0;
                    norm_next      = '0;
                    cnt_next       = '0;
                    draining_next  = 1'b0;
                    state_next     = glmt_pkg::ST_IDLE;
                end
            end
            default: state_next = glmt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= glmt_pkg::ST_IDLE;
            fill_reg       <= '0;
            norm_reg       <= '0;
            cnt_reg        <= '0;
            draining_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
            from_match_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            norm_reg       <= norm_next;
            cnt_reg        <= cnt_next;
            draining_reg   <= draining_next;
            rd_valid_reg   <= rd_valid_next;
            from_match_reg <= from_match_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        window_reg    <= window_next;
        space_reg     <= space_next;
        byte_reg      <= byte_next;
        pidx_reg      <= pidx_next;
        scan_reg      <= scan_next;
        match_len_reg <= match_len_next;
        best_id_reg   <= best_id_next;
        emit_id_reg   <= emit_id_next;
        consume_reg   <= consume_next;
        out_id_reg    <= out_id_next;
        out_tv_reg    <= out_tv_next;
        out_last_reg  <= out_last_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign token_id    = out_id_reg;
    assign token_valid = out_tv_reg;
    assign last        = out_last_reg;
    assign token_count = out_cnt_reg;

    // The window never holds more bytes than it has room for.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(WINDOW_LEN))
        else $error("window fill above its size");

    // Consuming bytes only happens while the window holds some.
    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == glmt_pkg::ST_SHIFT |-> fill_reg != '0)
        else $error("shift on an empty window");

    // An end beat always starts the drain.
    a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && glmt_pkg::kind_t'(kind) == glmt_pkg::KIND_END
        |=> state_reg == glmt_pkg::ST_DRAIN)
        else $error("end beat did not start the drain");

    // A beat without a token is always the closing beat.
    a_close_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !token_valid |-> last)
        else $error("closing beat without last");

endmodule
`default_nettype wire
